>>> rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FNPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FNPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/fnpa_pkg.sv
// Types, constants and codes of the fixed node pool allocator.
package fnpa_pkg;

	localparam int MAX_NODES      = 256;
	localparam int MAX_NODE_BYTES = 64;

	localparam int ID_W      = $clog2(MAX_NODES);
	localparam int BIDX_W    = $clog2(MAX_NODE_BYTES);
	localparam int CNT_W     = 9;
	localparam int NB_W      = 7;
	localparam int STORE_AW  = ID_W + BIDX_W;
	localparam int WORD_BITS = 16;
	localparam int MAP_WORDS = MAX_NODES / WORD_BITS;
	localparam int WSEL_W    = $clog2(MAP_WORDS);
	localparam int WPOS_W    = $clog2(WORD_BITS);

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(256);
	localparam logic [NB_W-1:0]  NB_RESET  = NB_W'(64);
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_NODES);
	localparam logic [NB_W-1:0]  NB_MAX    = NB_W'(MAX_NODE_BYTES);

	// Configuration register indexes.
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic REG_NODE_BYTES = 1'b1;

	typedef enum logic [2:0] {
		REQ_ALLOC_FIRST = 3'd0,
		REQ_ALLOC_PREF  = 3'd1,
		REQ_FREE        = 3'd2,
		REQ_WRITE       = 3'd3,
		REQ_READ        = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_NONE_FREE = 3'd1,
		STS_RANGE     = 3'd2,
		STS_TAKEN     = 3'd3,
		STS_SPAN      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_READ,
		FSM_EXEC
	} fsm_t;

	// Effective configuration, already limited to the pool size.
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [NB_W-1:0]  nb;
	} cfg_t;

	// Update of one in-use bit.
	typedef struct packed {
		logic            we;
		logic            set;
		logic [ID_W-1:0] id;
	} map_cmd_t;

	// First-free search result and the in-use bit of the queried node.
	typedef struct packed {
		logic            found;
		logic [ID_W-1:0] free_id;
		logic            used;
	} map_res_t;

endpackage

>>> rtl/fnpa_cfg.sv
// APB configuration registers of the allocator.
module fnpa_cfg import fnpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [CNT_W-1:0] node_count_q;
	logic [NB_W-1:0]  node_bytes_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_RESET;
			node_bytes_q <= NB_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_NODE_COUNT: node_count_q <= pwdata[CNT_W-1:0];
				REG_NODE_BYTES: node_bytes_q <= pwdata[NB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_NODE_COUNT: prdata = 32'(node_count_q);
			REG_NODE_BYTES: prdata = 32'(node_bytes_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.cnt = (node_count_q > CNT_MAX) ? CNT_MAX : node_count_q;
	assign cfg.nb  = (node_bytes_q > NB_MAX) ? NB_MAX : node_bytes_q;

endmodule

>>> rtl/fnpa_map.sv
// In-use bitmap with a two-stage search for the lowest free node.
module fnpa_map import fnpa_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [CNT_W-1:0] cnt,
	input  logic [ID_W-1:0] query_id,
	input  map_cmd_t        cmd,
	output map_res_t        res
);

	logic [MAX_NODES-1:0]  map_q;
	logic [MAP_WORDS-1:0]  found_s1;
	logic [WPOS_W-1:0]     pos_s1 [MAP_WORDS];
	logic [MAP_WORDS-1:0]  found_c;
	logic [WPOS_W-1:0]     pos_c  [MAP_WORDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (cmd.we) begin
			map_q[cmd.id] <= cmd.set;
		end
	end

	// First stage: per 16-bit word, lowest free bit that lies below the node count.
	always_comb begin
		for (int w = 0; w < MAP_WORDS; w++) begin
			found_c[w] = 1'b0;
			pos_c[w]   = '0;
			for (int b = WORD_BITS - 1; b >= 0; b--) begin
				if (!map_q[w*WORD_BITS+b] && (CNT_W'(w*WORD_BITS+b) < cnt)) begin
					found_c[w] = 1'b1;
					pos_c[w]   = WPOS_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		found_s1 <= found_c;
		pos_s1   <= pos_c;
	end

	// Second stage: lowest word that holds a free node.
	always_comb begin
		res.found   = 1'b0;
		res.free_id = '0;
		res.used    = map_q[query_id];
		for (int w = MAP_WORDS - 1; w >= 0; w--) begin
			if (found_s1[w]) begin
				res.found   = 1'b1;
				res.free_id = {WSEL_W'(w), pos_s1[w]};
			end
		end
	end

endmodule

>>> rtl/fixed_node_pool_allocator_top.sv
// Top level of the fixed node pool allocator: request sequencer and node memories.
// Each request beat passes through the accept cycle, the read cycle in which the
// length and byte memories are read and the first-free search registers its
// per-word stage, and the execute cycle that writes the memories and the in-use
// bitmap and loads the result register. A new request is accepted once the
// previous one has left the execute cycle, also while its result still waits on
// the master side; a stalled result holds the execute cycle.
// No clearing pass follows reset: stored lengths carry one valid bit per node.
module fixed_node_pool_allocator_top import fnpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Request beats.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // node_id[7:0], byte_index[13:8], write_byte[21:14],
	                              // span_length[28:22], zero[31:29]
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	// Result beats.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // granted_node[7:0], read_byte[15:8]
	output logic [2:0]  m_tuser,  // status[2:0]
	// Configuration.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "assert_macros.svh"

	cfg_t     cfg;
	map_cmd_t map_cmd;
	map_res_t map_res;
	fsm_t     st_q, st_d;

	logic [2:0]        req_q;
	logic [ID_W-1:0]   id_q;
	logic [BIDX_W-1:0] bidx_q;
	logic [7:0]        wbyte_q;
	logic [NB_W-1:0]   span_q;

	logic [NB_W-1:0]   len_mem   [MAX_NODES];
	logic [7:0]        store_mem [2**STORE_AW];
	logic [MAX_NODES-1:0] len_vld_q;
	logic [NB_W-1:0]   len_rd_s2;
	logic              len_vld_s2;
	logic [7:0]        byte_rd_s2;

	logic              m_tvalid_q;
	status_t           status_q;
	logic [7:0]        granted_q;
	logic [7:0]        rbyte_q;

	logic              accept, rd_en, exec_go, out_free;
	logic              in_range, span_big, idx_past;
	logic [NB_W-1:0]   len_eff;
	status_t           status_c;
	logic [7:0]        granted_c, rbyte_c;
	logic              len_we, store_we;
	logic [NB_W-1:0]   len_wdata;
	logic [STORE_AW-1:0] store_addr;

	fnpa_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	fnpa_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.cnt     (cfg.cnt),
		.query_id(id_q),
		.cmd     (map_cmd),
		.res     (map_res)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		st_d = st_q;
		case (st_q)
			FSM_IDLE: if (s_tvalid) st_d = FSM_READ;
			FSM_READ: st_d = FSM_EXEC;
			FSM_EXEC: if (out_free) st_d = FSM_IDLE;
			default:  st_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (st_q == FSM_IDLE);
		rd_en    = (st_q == FSM_READ);
		exec_go  = (st_q == FSM_EXEC) && out_free;
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FSM_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= s_tuser;
			id_q    <= s_tdata[7:0];
			bidx_q  <= s_tdata[13:8];
			wbyte_q <= s_tdata[21:14];
			span_q  <= s_tdata[28:22];
		end
	end

	assign store_addr = {id_q, bidx_q};

	// Node memories: read in the read cycle, written when the execute cycle completes.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			len_rd_s2  <= len_mem[id_q];
			byte_rd_s2 <= store_mem[store_addr];
		end
		if (len_we) begin
			len_mem[id_q] <= len_wdata;
		end
		if (store_we) begin
			store_mem[store_addr] <= wbyte_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q  <= '0;
			len_vld_s2 <= 1'b0;
		end else begin
			if (rd_en) begin
				len_vld_s2 <= len_vld_q[id_q];
			end
			if (len_we) begin
				len_vld_q[id_q] <= 1'b1;
			end
		end
	end

	assign in_range = {1'b0, id_q} < cfg.cnt;
	assign span_big = span_q > cfg.nb;
	assign idx_past = {1'b0, bidx_q} >= span_q;
	assign len_eff  = len_vld_s2 ? len_rd_s2 : '0;

	always_comb begin
		status_c    = STS_OK;
		granted_c   = '0;
		rbyte_c     = '0;
		map_cmd.we  = 1'b0;
		map_cmd.set = 1'b0;
		map_cmd.id  = id_q;
		len_we      = 1'b0;
		len_wdata   = '0;
		store_we    = 1'b0;
		case (req_q)
			REQ_ALLOC_FIRST: begin
				if (map_res.found) begin
					granted_c   = 8'(map_res.free_id);
					map_cmd.we  = exec_go;
					map_cmd.set = 1'b1;
					map_cmd.id  = map_res.free_id;
				end else begin
					status_c = STS_NONE_FREE;
				end
			end
			REQ_ALLOC_PREF: begin
				if (!in_range) begin
					status_c = STS_RANGE;
				end else if (map_res.used) begin
					status_c = STS_TAKEN;
				end else begin
					granted_c   = 8'(id_q);
					map_cmd.we  = exec_go;
					map_cmd.set = 1'b1;
				end
			end
			REQ_FREE: begin
				if (!in_range) begin
					status_c = STS_RANGE;
				end else begin
					map_cmd.we = exec_go;
					len_we     = exec_go;
				end
			end
			REQ_WRITE: begin
				if (!in_range) begin
					status_c = STS_RANGE;
				end else if (!map_res.used) begin
					status_c = STS_TAKEN;
				end else if (span_big) begin
					status_c = STS_SPAN;
				end else if (span_q == '0) begin
					len_we = exec_go;
				end else if (idx_past) begin
					status_c = STS_SPAN;
				end else begin
					len_we    = exec_go;
					len_wdata = span_q;
					store_we  = exec_go;
				end
			end
			REQ_READ: begin
				if (!in_range) begin
					status_c = STS_RANGE;
				end else if (!map_res.used) begin
					status_c = STS_TAKEN;
				end else if (span_big || idx_past) begin
					status_c = STS_SPAN;
				end else if ({1'b0, bidx_q} < len_eff) begin
					rbyte_c = byte_rd_s2;
				end
			end
			default: ;
		endcase
	end

	// Result register lets the next request start while this beat waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q  <= status_c;
			granted_q <= granted_c;
			rbyte_q   <= rbyte_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {rbyte_q, granted_q};

	`FNPA_ASSERT_NXT(a_accept_reads, clk, arst_n, accept, st_q == FSM_READ, "accepted beat did not enter the read cycle")
	`FNPA_ASSERT_IMP(a_grant_in_range, clk, arst_n, (st_q == FSM_EXEC) && map_res.found, {1'b0, map_res.free_id} < cfg.cnt, "free node beyond node count")
	`FNPA_ASSERT_IMP(a_result_from_exec, clk, arst_n, $rose(m_tvalid_q), $past(st_q) == FSM_EXEC, "result loaded outside execute cycle")
	`FNPA_ASSERT_IMP(a_single_write, clk, arst_n, store_we, len_we && (st_q == FSM_EXEC), "byte stored without length update")

endmodule

>>> tb/sv/fnpa_result_check.sv
// Result checker for the node pool allocator: tracks the pool and compares every result beat.
module fnpa_result_check import fnpa_pkg::*; (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	input  logic                                       s_tready,
	input  logic [31:0]                                s_tdata,
	input  logic [2:0]                                 s_tuser,
	input  logic                                       m_tvalid,
	input  logic                                       m_tready,
	input  logic [15:0]                                m_tdata,
	input  logic [2:0]                                 m_tuser,
	input  logic                                       psel,
	input  logic                                       penable,
	input  logic                                       pwrite,
	input  logic [2:0]                                 paddr,
	input  logic [31:0]                                pwdata,
	input  logic                                       pready,
	output int unsigned                                errors,
	output int unsigned                                pending,
	output int unsigned                                checked,
	output logic [MAX_NODES-1:0]                       node_busy,
	output logic [MAX_NODES-1:0][NB_W-1:0]             node_len,
	output logic [MAX_NODES-1:0][MAX_NODE_BYTES-1:0]   known_mask
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t    status;
		logic [7:0] granted;
		logic [7:0] rdbyte;
	} pool_result_t;

	logic [CNT_W-1:0] pool_count;
	logic [NB_W-1:0]  slot_bytes;
	logic [7:0]       slot_mem [MAX_NODES*MAX_NODE_BYTES];
	pool_result_t     expected_results [$];

	// Applies one request to the tracked pool and returns the result it must produce.
	function automatic pool_result_t serve_request(input logic [2:0] req, input logic [7:0] id,
			input logic [5:0] bidx, input logic [7:0] wbyte, input logic [6:0] span);
		pool_result_t res;
		int cnt;
		int nb;
		cnt = (pool_count > CNT_MAX) ? MAX_NODES : int'(pool_count);
		nb = (slot_bytes > NB_MAX) ? MAX_NODE_BYTES : int'(slot_bytes);
		res = '{status: STS_OK, granted: 8'd0, rdbyte: 8'd0};
		case (req)
			REQ_ALLOC_FIRST: begin
				res.status = STS_NONE_FREE;
				for (int i = 0; i < cnt && res.status != STS_OK; i++) begin
					if (!node_busy[i]) begin
						node_busy[i] = 1'b1;
						res.status = STS_OK;
						res.granted = 8'(i);
					end
				end
			end
			REQ_ALLOC_PREF: begin
				if (id >= cnt)
					res.status = STS_RANGE;
				else if (node_busy[id])
					res.status = STS_TAKEN;
				else begin
					node_busy[id] = 1'b1;
					res.granted = id;
				end
			end
			REQ_FREE: begin
				// A free of an idle node still succeeds and clears it.
				if (id >= cnt)
					res.status = STS_RANGE;
				else begin
					node_busy[id] = 1'b0;
					node_len[id] = '0;
				end
			end
			REQ_WRITE: begin
				if (id >= cnt)
					res.status = STS_RANGE;
				else if (!node_busy[id])
					res.status = STS_TAKEN;
				else if (span > nb)
					res.status = STS_SPAN;
				else if (span == 0)
					node_len[id] = '0;
				else if (bidx >= span)
					res.status = STS_SPAN;
				else begin
					slot_mem[{id, bidx}] = wbyte;
					known_mask[id][bidx] = 1'b1;
					node_len[id] = span;
				end
			end
			REQ_READ: begin
				if (id >= cnt)
					res.status = STS_RANGE;
				else if (!node_busy[id])
					res.status = STS_TAKEN;
				else if (span > nb || bidx >= span)
					res.status = STS_SPAN;
				else if (bidx < node_len[id])
					res.rdbyte = slot_mem[{id, bidx}];
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pool_result_t want;
		if (!arst_n) begin
			pool_count = CNT_RESET;
			slot_bytes = NB_RESET;
			node_busy = '0;
			node_len = '0;
			known_mask = '0;
			expected_results.delete();
			errors = 0;
			checked = 0;
			pending = 0;
		end else begin
			// Retire the oldest expectation before queuing a request accepted on this edge.
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing outstanding: status %0d, granted_node %0d, read_byte %0d",
						m_tuser, m_tdata[7:0], m_tdata[15:8]);
					errors++;
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						errors++;
					end
					if (m_tdata[7:0] !== want.granted) begin
						$error("granted_node: expected %0d, got %0d", want.granted, m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[15:8] !== want.rdbyte) begin
						$error("read_byte: expected 0x%02h, got 0x%02h", want.rdbyte, m_tdata[15:8]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(serve_request(s_tuser, s_tdata[7:0], s_tdata[13:8],
					s_tdata[21:14], s_tdata[28:22]));
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_NODE_BYTES)
					slot_bytes = pwdata[NB_W-1:0];
				else
					pool_count = pwdata[CNT_W-1:0];
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Top of the node pool allocator testbench: clock, reset, request and register stimulus, verdict.
module testbench import fnpa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // node_id[7:0], byte_index[13:8], write_byte[21:14],
	                       // span_length[28:22], zero[31:29]
	logic [2:0]  s_tuser;  // req_type[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // granted_node[7:0], read_byte[15:8]
	logic [2:0]  m_tuser;  // status[2:0]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned                               fail_count;
	int unsigned                               pending;
	int unsigned                               checked;
	logic [MAX_NODES-1:0]                      node_busy;
	logic [MAX_NODES-1:0][NB_W-1:0]            node_len;
	logic [MAX_NODES-1:0][MAX_NODE_BYTES-1:0]  known_mask;

	int unsigned items_sent;
	int unsigned settings_used;
	int          cur_count;
	int          cur_bytes;
	bit          quiet;
	int          hold_left;

	fixed_node_pool_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	fnpa_result_check u_result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.errors     (fail_count),
		.pending    (pending),
		.checked    (checked),
		.node_busy  (node_busy),
		.node_len   (node_len),
		.known_mask (known_mask)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("fixed_node_pool_allocator_top: mismatch");
		$finish;
	end

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 94)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	// Result side: random back-pressure, suspended during quiet stretches.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0)
				hold_left = gap_cycles();
		end
	end

	// Finds an allocated node below the count, starting at a random place.
	function automatic logic pick_busy(input int ncnt, output logic [7:0] pick);
		int start;
		int j;
		pick = 8'd0;
		if (ncnt == 0)
			return 1'b0;
		start = $urandom_range(0, ncnt - 1);
		for (int k = 0; k < ncnt; k++) begin
			j = (start + k) % ncnt;
			if (node_busy[j]) begin
				pick = 8'(j);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Bytes below the stored length that were never written must not be read, so such an
	// index is moved to a written byte. The byte of the write that set the length always is.
	function automatic logic [5:0] safe_read_index(input logic [7:0] id, input logic [5:0] bidx);
		int start;
		logic [5:0] j;
		if (bidx >= node_len[id] || known_mask[id][bidx])
			return bidx;
		start = $urandom_range(0, 63);
		for (int k = 0; k < 64; k++) begin
			j = 6'(start + k);
			if (j < node_len[id] && known_mask[id][j])
				return j;
		end
		return bidx;
	endfunction

	task automatic issue_request(input logic [2:0] req, input logic [7:0] id,
			input logic [5:0] bidx, input logic [7:0] wbyte, input logic [6:0] span);
		int gap;
		gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : gap_cycles();
		if (req == REQ_READ)
			bidx = safe_read_index(id, bidx);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {3'b000, span, wbyte, bidx, id};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic setup_pool(input int count, input int bytes);
		drain_results();
		write_reg(REG_NODE_COUNT, 32'(count));
		write_reg(REG_NODE_BYTES, 32'(bytes));
		cur_count = count;
		cur_bytes = bytes;
		settings_used++;
	endtask

	// Mostly requests aimed at allocated nodes with spans that fit, plus raw noise.
	task automatic random_request();
		logic [2:0] req;
		logic [7:0] id;
		logic [5:0] bidx;
		logic [7:0] wbyte;
		logic [6:0] span;
		logic [7:0] busy_id;
		logic       have_busy;
		int         r;
		int         ncnt;
		int         nb;
		int         lim;
		ncnt = (cur_count > MAX_NODES) ? MAX_NODES : cur_count;
		nb = (cur_bytes > MAX_NODE_BYTES) ? MAX_NODE_BYTES : cur_bytes;
		r = $urandom_range(0, 99);
		req = REQ_ALLOC_FIRST;
		id = 8'($urandom_range(0, 255));
		bidx = 6'($urandom_range(0, 63));
		wbyte = 8'($urandom_range(0, 255));
		span = 7'($urandom_range(0, 64));
		have_busy = pick_busy(ncnt, busy_id);
		if (r < 4) begin
			req = 3'($urandom_range(0, 7));
		end else if (r < 16) begin
			req = REQ_ALLOC_FIRST;
		end else if (r < 26) begin
			req = REQ_ALLOC_PREF;
			if (ncnt != 0 && $urandom_range(0, 3) != 0)
				id = 8'($urandom_range(0, ncnt - 1));
		end else if (r < 36) begin
			req = REQ_FREE;
			if (have_busy && $urandom_range(0, 1) == 0)
				id = busy_id;
		end else begin
			req = (r < 68) ? REQ_WRITE : REQ_READ;
			if (have_busy && $urandom_range(0, 4) != 0)
				id = busy_id;
			else if (ncnt != 0 && $urandom_range(0, 1) == 0)
				id = 8'($urandom_range(0, ncnt - 1));
			if (nb != 0 && $urandom_range(0, 9) != 0) begin
				span = 7'($urandom_range(1, nb));
				bidx = 6'($urandom_range(0, span - 1));
				if (req == REQ_READ && node_len[id] != 0 && $urandom_range(0, 1) == 0) begin
					lim = (span < node_len[id]) ? int'(span) : int'(node_len[id]);
					bidx = 6'($urandom_range(0, lim - 1));
				end
			end else if (req == REQ_WRITE && $urandom_range(0, 1) == 0) begin
				span = 7'd0;
			end
		end
		issue_request(req, id, bidx, wbyte, span);
	endtask

	task automatic run_phase(input int count, input int bytes, input int n, input bit calm);
		setup_pool(count, bytes);
		quiet = calm;
		for (int i = 0; i < n; i++) begin
			// Now and then let the whole pipeline empty before going on.
			if (i != 0 && i % 150 == 0)
				drain_results();
			random_request();
		end
		quiet = 1'b0;
	endtask

	task automatic directed_checks();
		issue_request(REQ_ALLOC_FIRST, 8'd0, 6'd0, 8'd0, 7'd0);
		issue_request(REQ_ALLOC_PREF, 8'hFF, 6'd0, 8'd0, 7'd0);
		issue_request(REQ_ALLOC_PREF, 8'hFF, 6'd0, 8'd0, 7'd0);
		issue_request(REQ_WRITE, 8'hFF, 6'h3F, 8'hFF, 7'd64);
		issue_request(REQ_READ, 8'hFF, 6'h3F, 8'd0, 7'd64);
		issue_request(REQ_WRITE, 8'd0, 6'd0, 8'hA5, 7'd1);
		issue_request(REQ_READ, 8'd0, 6'd0, 8'd0, 7'd64);
		issue_request(REQ_WRITE, 8'd0, 6'd5, 8'h3C, 7'd3);
		issue_request(REQ_READ, 8'd0, 6'd3, 8'd0, 7'd3);
		issue_request(REQ_READ, 8'd0, 6'd0, 8'd0, 7'd0);
		issue_request(REQ_WRITE, 8'd1, 6'd0, 8'h11, 7'd1);
		// A zero-length write only clears the stored length.
		issue_request(REQ_WRITE, 8'd0, 6'd0, 8'h00, 7'd0);
		issue_request(REQ_READ, 8'd0, 6'd0, 8'd0, 7'd1);
		issue_request(REQ_FREE, 8'd0, 6'd0, 8'd0, 7'd0);
		issue_request(REQ_FREE, 8'd7, 6'd0, 8'd0, 7'd0);
		issue_request(REQ_READ, 8'd0, 6'd0, 8'd0, 7'd1);
		issue_request(REQ_SPARE_LO, 8'hFF, 6'h3F, 8'hFF, 7'd64);
		issue_request(REQ_SPARE_HI, 8'd0, 6'd0, 8'd0, 7'd0);

		// Tiny pool: fill it, then ask once more.
		setup_pool(4, 1);
		repeat (5) issue_request(REQ_ALLOC_FIRST, 8'd0, 6'd0, 8'd0, 7'd0);
		issue_request(REQ_ALLOC_PREF, 8'd4, 6'd0, 8'd0, 7'd0);
		issue_request(REQ_WRITE, 8'd2, 6'd0, 8'h5A, 7'd2);
		issue_request(REQ_READ, 8'hFF, 6'h3F, 8'd0, 7'd1);

		setup_pool(0, 64);
		issue_request(REQ_ALLOC_FIRST, 8'd0, 6'd0, 8'd0, 7'd0);
		issue_request(REQ_FREE, 8'd0, 6'd0, 8'd0, 7'd0);

		// Oversized register values are limited to the pool; node 255 kept its data.
		setup_pool(511, 127);
		issue_request(REQ_READ, 8'hFF, 6'h3F, 8'd0, 7'd64);

		setup_pool(256, 0);
		issue_request(REQ_WRITE, 8'hFF, 6'd0, 8'h77, 7'd0);
		issue_request(REQ_WRITE, 8'hFF, 6'd0, 8'h77, 7'd1);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet = 1'b0;
		hold_left = 0;
		items_sent = 0;
		settings_used = 0;
		cur_count = 256;
		cur_bytes = 64;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_checks();
		run_phase(256, 64, 260, 1'b0);
		run_phase(16, 8, 200, 1'b0);
		run_phase(1, 1, 90, 1'b0);
		run_phase(256, 64, 250, 1'b1);
		run_phase(37, 64, 200, 1'b0);
		run_phase(200, 17, 200, 1'b0);
		run_phase(511, 127, 250, 1'b0);

		drain_results();
		repeat (8) @(negedge clk);
		$display("Sent %0d requests over %0d pool settings, from a full one-node pool to oversized registers.",
			items_sent, settings_used);
		$display("Compared %0d result beats field by field.", checked);
		if (fail_count == 0)
			$display("fixed_node_pool_allocator_top: match");
		else
			$display("fixed_node_pool_allocator_top: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/fnpa_pkg.sv
rtl/fnpa_cfg.sv
rtl/fnpa_map.sv
rtl/fixed_node_pool_allocator_top.sv
tb/sv/fnpa_result_check.sv
tb/sv/testbench.sv
